/* design/hst_pkg.sv */
// shared types, constants and character tables for the handler number text scanner
package hst_pkg;

  localparam int NUMBER_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int HANDLER_BITS        = 16;

  localparam logic [31:0] PRODUCT_CODE_RESET = 32'h3032_6561;

  localparam logic [3:0] ID_TERM_LEN    = 4'd12;
  localparam logic [3:0] EVENT_TERM_LEN = 4'd5;

  localparam logic [7:0] CHAR_I       = 8'h49;
  localparam logic [7:0] CHAR_H       = 8'h48;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_0       = 8'h30;
  localparam logic [7:0] CHAR_9       = 8'h39;

  localparam logic REG_PRODUCT_CODE = 1'b0;

  typedef enum logic [1:0] {
    MODE_IGNORE = 2'd0,
    MODE_ID     = 2'd1,
    MODE_EVENT  = 2'd2
  } search_mode_t;

  typedef struct packed {
    logic                    found;
    logic [HANDLER_BITS-1:0] handler_number;
  } result_t;

  // expected character of "Product=" followed by the configured code
  function automatic logic [7:0] id_char(input logic [3:0] pos, input logic [31:0] code);
    logic [7:0] ch;
    case (pos)
      4'd0: ch = 8'h50;
      4'd1: ch = 8'h72;
      4'd2: ch = 8'h6f;
      4'd3: ch = 8'h64;
      4'd4: ch = 8'h75;
      4'd5: ch = 8'h63;
      4'd6: ch = 8'h74;
      4'd7: ch = 8'h3d;
      4'd8: ch = code[31:24];
      4'd9: ch = code[23:16];
      4'd10: ch = code[15:8];
      4'd11: ch = code[7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // expected character of "event"
  function automatic logic [7:0] event_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h65;
      3'd1: ch = 8'h76;
      3'd2: ch = 8'h65;
      3'd3: ch = 8'h6e;
      3'd4: ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* design/handler_number_text_scanner_top.sv */
// top level: stream ports, configuration register, scanner front and result queue
// result path: a result is registered in the result queue as its byte is taken, then offered on the master side
// throughput: one byte per cycle; input stalls only while the result queue is full
// queue depth (QUEUE_DEPTH) sets how many results may wait for the downstream side
// reset: synchronous, active high; clears scanner state and queue, code to "02ea"
module handler_number_text_scanner_top #(
  parameter int NUMBER_BITS = hst_pkg::NUMBER_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = hst_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // text_byte
  input  logic        s_axis_tlast,  // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // handler_number
  output logic        m_axis_tuser,  // found
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hst_pkg::*;

  logic [31:0] product_code;
  logic        in_fire;
  logic        queue_full;
  logic        result_valid;
  result_t     result;
  result_t     out_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PRODUCT_CODE) ? product_code : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      product_code <= PRODUCT_CODE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PRODUCT_CODE) begin
      product_code <= pwdata;
    end
  end

  assign s_axis_tready = !queue_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  hst_front #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .text_byte    (s_axis_tdata),
    .end_of_text  (s_axis_tlast),
    .product_code (product_code),
    .result_valid (result_valid),
    .result       (result)
  );

  hst_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (result_valid),
    .push_data (result),
    .full      (queue_full),
    .pop_valid (m_axis_tvalid),
    .pop_ready (m_axis_tready),
    .pop_data  (out_data)
  );

  assign m_axis_tdata = out_data.handler_number;
  assign m_axis_tuser = out_data.found;

endmodule

/* design/hst_front.sv */
// front part: line classification, term matching and digit accumulation per byte
module hst_front #(
  parameter int NUMBER_BITS = hst_pkg::NUMBER_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic [7:0]       text_byte,
  input  logic             end_of_text,
  input  logic [31:0]      product_code,
  output logic             result_valid,
  output hst_pkg::result_t result
);
  import hst_pkg::*;

  localparam int PROD_BITS = NUMBER_BITS + 4;

  logic                   at_line_start, at_line_start_next;
  search_mode_t           search_mode, search_mode_next;
  logic [3:0]             match_position, match_position_next;
  logic                   id_seen, id_seen_next;
  logic [NUMBER_BITS-1:0] number_accumulator, number_accumulator_next;
  logic                   already_reported, already_reported_next;

  logic [PROD_BITS-1:0]   acc_ext;
  logic [PROD_BITS-1:0]   acc_prod;
  logic [3:0]             digit;
  logic                   is_digit;
  logic                   report;
  logic                   run_started;
  logic [31:0]            number_wide;
  search_mode_t           mode_cur;

  assign digit    = 4'(text_byte - CHAR_0);
  assign acc_ext  = PROD_BITS'(number_accumulator);
  assign acc_prod = (acc_ext << 3) + (acc_ext << 1) + PROD_BITS'(digit);

  always_comb begin
    at_line_start_next      = at_line_start;
    search_mode_next        = search_mode;
    match_position_next     = match_position;
    id_seen_next            = id_seen;
    number_accumulator_next = number_accumulator;
    already_reported_next   = already_reported;
    report                  = 1'b0;
    run_started             = 1'b0;
    result_valid            = 1'b0;
    mode_cur                = search_mode;
    is_digit                = text_byte inside {[CHAR_0:CHAR_9]};

    if (in_fire && !already_reported) begin
      if (at_line_start) begin
        if (text_byte == CHAR_I) begin
          mode_cur = MODE_ID;
        end else if (id_seen && text_byte == CHAR_H) begin
          mode_cur = MODE_EVENT;
        end else begin
          mode_cur = MODE_IGNORE;
        end
      end
      search_mode_next = mode_cur;

      case (mode_cur)
        MODE_ID: begin
          if (match_position < ID_TERM_LEN &&
              text_byte == id_char(match_position, product_code)) begin
            match_position_next = match_position + 4'd1;
          end else begin
            id_seen_next        = (match_position >= ID_TERM_LEN);
            search_mode_next    = (match_position >= ID_TERM_LEN) ? MODE_IGNORE : MODE_ID;
            match_position_next = 4'd0;
          end
        end
        MODE_EVENT: begin
          if (match_position < EVENT_TERM_LEN &&
              text_byte == event_char(match_position[2:0])) begin
            match_position_next = match_position + 4'd1;
          end else if (match_position >= EVENT_TERM_LEN) begin
            run_started = 1'b1;
            if (is_digit) begin
              if (|acc_prod[PROD_BITS-1:NUMBER_BITS]) begin
                number_accumulator_next = '1;
              end else begin
                number_accumulator_next = acc_prod[NUMBER_BITS-1:0];
              end
            end else begin
              report = 1'b1;
            end
          end else begin
            match_position_next = 4'd0;
          end
        end
        default: begin
        end
      endcase

      at_line_start_next = (text_byte == CHAR_NEWLINE);
      if (end_of_text && run_started) begin
        report = 1'b1;
      end
      if (report) begin
        already_reported_next = 1'b1;
      end
      result_valid = report || end_of_text;
    end

    number_wide           = 32'(number_accumulator_next);
    result.found          = report;
    result.handler_number = report ? number_wide[HANDLER_BITS-1:0] : '0;

    // re-arm after the last byte
    if (in_fire && end_of_text) begin
      at_line_start_next      = 1'b1;
      search_mode_next        = MODE_IGNORE;
      match_position_next     = 4'd0;
      id_seen_next            = 1'b0;
      number_accumulator_next = '0;
      already_reported_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start      <= 1'b1;
      search_mode        <= MODE_IGNORE;
      match_position     <= 4'd0;
      id_seen            <= 1'b0;
      number_accumulator <= '0;
      already_reported   <= 1'b0;
    end else begin
      at_line_start      <= at_line_start_next;
      search_mode        <= search_mode_next;
      match_position     <= match_position_next;
      id_seen            <= id_seen_next;
      number_accumulator <= number_accumulator_next;
      already_reported   <= already_reported_next;
    end
  end

endmodule

/* design/hst_queue.sv */
// result queue between the scanner front and the output stream
module hst_queue #(
  parameter int DEPTH = hst_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hst_pkg::result_t push_data,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop_ready,
  output hst_pkg::result_t pop_data
);
  import hst_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  result_t             mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == CNT_BITS'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* tb/tb_handler_number_text_scanner_top.sv */
// self-checking testbench for the handler number text scanner: stream, config and prediction
`timescale 1ns / 100ps

module tb_handler_number_text_scanner_top;
  import hst_pkg::*;

  localparam int          DIRECTED_COUNT = 24;
  localparam int          PHASE_COUNT    = 6;
  localparam int          PHASE_ITEMS    = 350;
  localparam int          STALL_LIMIT    = 2000;
  localparam logic [2:0]  CODE_ADDR      = 3'(REG_PRODUCT_CODE) << 2;
  localparam logic [63:0] PREFIX_CHARS   = "Product=";
  localparam logic [39:0] EVENT_CHARS    = "event";
  localparam logic [15:0] NUMBER_MAX     = 16'hffff;

  typedef struct packed {
    logic [7:0]  text;
    logic        eot;
    logic        typed;
    logic        want_found;
    logic [15:0] want_number;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{"x", 1'b1, 1'b1, 1'b0, 16'd0},
    '{CHAR_I, 1'b0, 1'b0, 1'b0, 16'd0},
    '{"P", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"r", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"o", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"d", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"u", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"c", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"t", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"=", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"0", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"2", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"e", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"a", 1'b0, 1'b0, 1'b0, 16'd0},
    '{CHAR_NEWLINE, 1'b0, 1'b0, 1'b0, 16'd0},
    '{CHAR_H, 1'b0, 1'b0, 1'b0, 16'd0},
    '{"e", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"v", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"e", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"n", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"t", 1'b0, 1'b0, 1'b0, 16'd0},
    '{"7", 1'b1, 1'b1, 1'b1, 16'd7},
    '{8'hff, 1'b1, 1'b1, 1'b0, 16'd0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 16'd0}
  };

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  handler_number_text_scanner_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // scanner state as predicted
  logic         sc_line_start;
  search_mode_t sc_mode;
  logic [3:0]   sc_pos;
  logic         sc_id_seen;
  logic [15:0]  sc_number;
  logic         sc_reported;
  logic [31:0]  sc_code;

  result_t    pending_reports [$];
  logic [7:0] listing_q [$];
  int         error_count = 0;
  int         stall_cycles;
  bit         send_idle_on;
  bit         sink_idle_on;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void rearm_scan();
    sc_line_start = 1'b1;
    sc_mode       = MODE_IGNORE;
    sc_pos        = 4'd0;
    sc_id_seen    = 1'b0;
    sc_number     = 16'd0;
    sc_reported   = 1'b0;
  endfunction

  function automatic logic [7:0] id_term_char(input logic [3:0] pos);
    int p;
    p = pos;
    if (p < 8) return PREFIX_CHARS[8*(7-p) +: 8];
    return sc_code[8*(11-p) +: 8];
  endfunction

  function automatic logic [7:0] event_term_char(input logic [3:0] pos);
    int p;
    p = pos;
    return EVENT_CHARS[8*(4-p) +: 8];
  endfunction

  function automatic void scan_text_byte(input logic [7:0] c, input logic eot,
                                         output logic got, output result_t res);
    logic        report;
    logic        run_started;
    logic [31:0] grown;
    got = 1'b0;
    res = '0;
    report = 1'b0;
    run_started = 1'b0;
    if (sc_reported) begin
      if (eot) rearm_scan();
      return;
    end
    if (sc_line_start) begin
      if (c == CHAR_I) sc_mode = MODE_ID;
      else if (sc_id_seen && c == CHAR_H) sc_mode = MODE_EVENT;
      else sc_mode = MODE_IGNORE;
    end
    if (sc_mode == MODE_ID) begin
      if (sc_pos < ID_TERM_LEN && c == id_term_char(sc_pos)) begin
        sc_pos = sc_pos + 4'd1;
      end else begin
        sc_id_seen = (sc_pos >= ID_TERM_LEN);
        sc_mode = sc_id_seen ? MODE_IGNORE : MODE_ID;
        sc_pos = 4'd0;
      end
    end else if (sc_mode == MODE_EVENT) begin
      if (sc_pos < EVENT_TERM_LEN && c == event_term_char(sc_pos)) begin
        sc_pos = sc_pos + 4'd1;
      end else if (sc_pos >= EVENT_TERM_LEN) begin
        run_started = 1'b1;
        if (c >= CHAR_0 && c <= CHAR_9) begin
          grown = 32'(sc_number) * 32'd10 + 32'(c - CHAR_0);
          sc_number = (grown > 32'(NUMBER_MAX)) ? NUMBER_MAX : grown[15:0];
        end else begin
          report = 1'b1;
        end
      end else begin
        sc_pos = 4'd0;
      end
    end
    sc_line_start = (c == CHAR_NEWLINE);
    if (eot && run_started) report = 1'b1;
    if (report) begin
      sc_reported = 1'b1;
      res.found = 1'b1;
      res.handler_number = sc_number;
      got = 1'b1;
      if (eot) rearm_scan();
    end else if (eot) begin
      got = 1'b1;
      rearm_scan();
    end
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eot, input logic typed,
                           input result_t want);
    logic    got;
    result_t res;
    while (send_idle_on && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eot;
    do @(posedge clk); while (!s_axis_tready);
    scan_text_byte(c, eot, got, res);
    if (typed) begin
      got = 1'b1;
      res = want;
    end
    if (got) pending_reports.push_back(res);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sc_code = data;
  endtask

  task automatic wait_drained();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] non_digit_byte();
    logic [7:0] b;
    do b = random_byte(); while (b >= CHAR_0 && b <= CHAR_9);
    return b;
  endfunction

  function automatic void add_chars(input logic [63:0] chars, input int count);
    for (int k = count - 1; k >= 0; k--) listing_q.push_back(chars[8*k +: 8]);
  endfunction

  // listing of well-formed id and handler lines with random content, plus broken lines and noise
  function automatic void build_listing();
    int lines;
    int kind;
    int n;
    int start;
    bit last_line;
    listing_q.delete();
    lines = $urandom_range(1, 6);
    for (int ln = 0; ln < lines; ln++) begin
      last_line = (ln == lines - 1);
      kind = $urandom_range(99);
      start = listing_q.size();
      if (kind < 40) begin
        listing_q.push_back(CHAR_I);
        if ($urandom_range(7) == 0) listing_q.push_back(random_byte());
        add_chars(PREFIX_CHARS, 8);
        add_chars(64'(sc_code), 4);
        if (kind >= 30) listing_q[$urandom_range(listing_q.size() - 1, start + 1)] = random_byte();
        if (!(last_line && $urandom_range(1) == 0)) listing_q.push_back(CHAR_NEWLINE);
      end else if (kind < 75) begin
        listing_q.push_back(CHAR_H);
        if ($urandom_range(3) == 0) begin
          listing_q.push_back("e");
          listing_q.push_back(random_byte());
        end
        add_chars(64'(EVENT_CHARS), 5);
        n = ($urandom_range(3) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
        repeat (n) listing_q.push_back(($urandom_range(3) == 0) ? CHAR_9
                                       : 8'(CHAR_0 + $urandom_range(9)));
        if (!(last_line && $urandom_range(1) == 0))
          listing_q.push_back($urandom_range(1) ? CHAR_NEWLINE : non_digit_byte());
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) listing_q.push_back(random_byte());
        if (!(last_line && $urandom_range(1) == 0)) listing_q.push_back(CHAR_NEWLINE);
      end
    end
  endfunction

  function automatic logic [31:0] phase_code(input int phase);
    logic [31:0] code;
    case (phase)
      0: code = 32'h0000_0000;
      1: code = 32'hffff_ffff;
      2: code = 32'h3132_330a;
      3: code = $urandom();
      4: begin
        for (int k = 0; k < 4; k++) code[8*k +: 8] = 8'($urandom_range(8'h7e, 8'h21));
      end
      default: code = PRODUCT_CODE_RESET;
    endcase
    return code;
  endfunction

  always @(posedge clk) begin
    m_axis_tready <= !sink_idle_on || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result transfer: found=%0b handler_number=%0d",
                   m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_reports.pop_front();
        if (m_axis_tuser !== want.found || m_axis_tdata !== want.handler_number) begin
          error_count++;
          if (error_count <= 10)
            $display("result mismatch: expected found=%0b handler_number=%0d, got found=%0b handler_number=%0d",
                     want.found, want.handler_number, m_axis_tuser, m_axis_tdata);
        end
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int phase_items;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 3'd0;
    pwdata        = 32'd0;
    send_idle_on  = 1'b1;
    sink_idle_on  = 1'b1;
    sc_code       = PRODUCT_CODE_RESET;
    rearm_scan();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_COUNT; r++)
      send_byte(DIRECTED_ROWS[r].text, DIRECTED_ROWS[r].eot, DIRECTED_ROWS[r].typed,
                {DIRECTED_ROWS[r].want_found, DIRECTED_ROWS[r].want_number});

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      apb_write(CODE_ADDR, phase_code(phase));
      send_idle_on = (phase != 4);
      sink_idle_on = (phase != 4);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_listing();
        for (int k = 0; k < listing_q.size(); k++)
          send_byte(listing_q[k], k == listing_q.size() - 1, 1'b0, '0);
        phase_items += listing_q.size();
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_reports.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
design/hst_pkg.sv
design/hst_front.sv
design/hst_queue.sv
design/handler_number_text_scanner_top.sv
tb/tb_handler_number_text_scanner_top.sv
